// File: rtl/assert_macros.svh
// Assertion helpers for the sensor frame reader.
// Every macro samples on clk and is held off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check; prop may use |-> or |=>.
`define SWR_ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Plain invariant checked at every rising clock edge.
`define SWR_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`endif

// File: rtl/swr_pkg.sv
package swr_pkg;

  localparam int FRAME_BITS = 40;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_INDEX_W = 3;

  localparam logic [23:0] SINCE_MAX = 24'hFFFFFF;

  // Read sequence phases.
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_START_LOW,
    PH_START_HIGH,
    PH_ACK_LOW,
    PH_ACK_HIGH,
    PH_BIT_LOW,
    PH_BIT_HIGH
  } phase_t;

  // Read status codes.
  typedef enum logic [1:0] {
    ST_OK,
    ST_ACK_TIMEOUT,
    ST_DATA_TIMEOUT,
    ST_CHECKSUM
  } status_t;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_MIN_INTERVAL,
    CFG_START_LOW,
    CFG_START_HIGH,
    CFG_ACK_TIMEOUT,
    CFG_BIT_LOW_TIMEOUT,
    CFG_BIT_HIGH_TIMEOUT
  } cfg_index_t;

  typedef struct packed {
    logic [23:0] min_interval_ticks;
    logic [15:0] start_low_ticks;
    logic [7:0]  start_high_ticks;
    logic [7:0]  ack_timeout;
    logic [7:0]  bit_low_timeout;
    logic [7:0]  bit_high_timeout;
  } cfg_t;

  typedef struct packed {
    logic               drive_enable;
    logic               drive_value;
    logic               busy_res;
    logic               done_res;
    logic               reused;
    logic [1:0]         status;
    logic [15:0]        humidity_tenths;
    logic signed [15:0] temperature_tenths;
  } res_t;

endpackage

// File: rtl/swr_cfg.sv
module swr_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [swr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [swr_pkg::CFG_DATA_W-1:0]   cfg_data,
  output swr_pkg::cfg_t                    cfg
);
  import swr_pkg::*;

  cfg_t cfg_next;

  always_comb begin
    cfg_next = cfg;
    if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_MIN_INTERVAL:     cfg_next.min_interval_ticks = cfg_data;
        CFG_START_LOW:        cfg_next.start_low_ticks = cfg_data[15:0];
        CFG_START_HIGH:       cfg_next.start_high_ticks = cfg_data[7:0];
        CFG_ACK_TIMEOUT:      cfg_next.ack_timeout = cfg_data[7:0];
        CFG_BIT_LOW_TIMEOUT:  cfg_next.bit_low_timeout = cfg_data[7:0];
        CFG_BIT_HIGH_TIMEOUT: cfg_next.bit_high_timeout = cfg_data[7:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_interval_ticks <= 24'd2000000;
      cfg.start_low_ticks    <= 16'd1100;
      cfg.start_high_ticks   <= 8'd25;
      cfg.ack_timeout        <= 8'd85;
      cfg.bit_low_timeout    <= 8'd56;
      cfg.bit_high_timeout   <= 8'd75;
    end else begin
      cfg <= cfg_next;
    end
  end

endmodule

// File: rtl/swr_core.sv
module swr_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  logic           action,
  input  logic           level,
  input  swr_pkg::cfg_t  cfg,
  output swr_pkg::res_t  res
);
  import swr_pkg::*;

  `include "assert_macros.svh"

  phase_t                phase, phase_next;
  logic [15:0]           phase_ticks, phase_ticks_next;
  logic [7:0]            pulse_ticks, pulse_ticks_next;
  logic [7:0]            low_pulse_length, low_pulse_length_next;
  logic [5:0]            bit_index, bit_index_next;
  logic [FRAME_BITS-1:0] frame_bits, frame_bits_next;
  logic [23:0]           since_last_read, since_last_read_next;
  status_t               last_status, last_status_next;
  logic [15:0]           last_humidity, last_humidity_next;
  logic [15:0]           last_temperature, last_temperature_next;

  logic                  done_flag;
  logic                  reused_flag;
  logic                  want_high;
  logic [7:0]            cur_timeout;
  logic [16:0]           ticks_inc;
  logic                  begin_pulse;
  phase_t                target;
  logic [FRAME_BITS-1:0] frame_shift;
  logic [5:0]            bit_index_inc;
  logic [7:0]            b0, b1, b2, b3, b4, sum8;
  logic [14:0]           mag;

  function automatic logic [7:0] timeout_of(phase_t ph, cfg_t c);
    priority if (ph == PH_ACK_LOW || ph == PH_ACK_HIGH) return c.ack_timeout;
    else if (ph == PH_BIT_LOW) return c.bit_low_timeout;
    else return c.bit_high_timeout;
  endfunction

  function automatic status_t fail_of(phase_t ph);
    return (ph == PH_ACK_LOW || ph == PH_ACK_HIGH) ? ST_ACK_TIMEOUT : ST_DATA_TIMEOUT;
  endfunction

  always_comb begin
    phase_next            = phase;
    phase_ticks_next      = phase_ticks;
    pulse_ticks_next      = pulse_ticks;
    low_pulse_length_next = low_pulse_length;
    bit_index_next        = bit_index;
    frame_bits_next       = frame_bits;
    since_last_read_next  = since_last_read;
    last_status_next      = last_status;
    last_humidity_next    = last_humidity;
    last_temperature_next = last_temperature;
    done_flag             = 1'b0;
    reused_flag           = 1'b0;
    begin_pulse           = 1'b0;
    target                = PH_BIT_LOW;

    want_high     = (phase == PH_ACK_HIGH) || (phase == PH_BIT_HIGH);
    cur_timeout   = timeout_of(phase, cfg);
    ticks_inc     = {1'b0, phase_ticks} + 17'd1;
    frame_shift   = {frame_bits[FRAME_BITS-2:0], (pulse_ticks > low_pulse_length)};
    bit_index_inc = bit_index + 6'd1;
    b0   = frame_shift[39:32];
    b1   = frame_shift[31:24];
    b2   = frame_shift[23:16];
    b3   = frame_shift[15:8];
    b4   = frame_shift[7:0];
    sum8 = b0 + b1 + b2 + b3;
    mag  = {b2[6:0], b3};

    if (action) begin
      if (phase == PH_IDLE) begin
        if (since_last_read < cfg.min_interval_ticks) begin
          done_flag   = 1'b1;
          reused_flag = 1'b1;
        end else begin
          since_last_read_next  = '0;
          frame_bits_next       = '0;
          bit_index_next        = '0;
          pulse_ticks_next      = '0;
          low_pulse_length_next = '0;
          phase_ticks_next      = '0;
          phase_next            = PH_START_LOW;
        end
      end
    end else begin
      if (since_last_read != SINCE_MAX) since_last_read_next = since_last_read + 24'd1;
      unique case (phase)
        PH_START_LOW: begin
          phase_ticks_next = ticks_inc[15:0];
          if (ticks_inc >= {1'b0, cfg.start_low_ticks}) begin
            phase_ticks_next = '0;
            pulse_ticks_next = '0;
            phase_next = (cfg.start_high_ticks == 8'd0) ? PH_ACK_LOW : PH_START_HIGH;
          end
        end
        PH_START_HIGH: begin
          phase_ticks_next = ticks_inc[15:0];
          if (ticks_inc >= 17'(cfg.start_high_ticks)) begin
            phase_ticks_next = '0;
            pulse_ticks_next = '0;
            phase_next       = PH_ACK_LOW;
          end
        end
        PH_ACK_LOW, PH_ACK_HIGH, PH_BIT_LOW, PH_BIT_HIGH: begin
          if (level == want_high) begin
            // Same level: count it, or abort when already at the limit.
            if (pulse_ticks >= cur_timeout) begin
              last_status_next = fail_of(phase);
              phase_next       = PH_IDLE;
              done_flag        = 1'b1;
            end else begin
              pulse_ticks_next = pulse_ticks + 8'd1;
            end
          end else begin
            unique case (phase)
              PH_ACK_LOW: begin
                begin_pulse = 1'b1;
                target      = PH_ACK_HIGH;
              end
              PH_ACK_HIGH: begin
                bit_index_next = '0;
                begin_pulse    = 1'b1;
                target         = PH_BIT_LOW;
              end
              PH_BIT_LOW: begin
                low_pulse_length_next = pulse_ticks;
                begin_pulse           = 1'b1;
                target                = PH_BIT_HIGH;
              end
              default: begin
                // End of a bit high pulse: shift in the bit.
                frame_bits_next = frame_shift;
                bit_index_next  = bit_index_inc;
                if (bit_index_inc >= 6'(FRAME_BITS)) begin
                  phase_next = PH_IDLE;
                  done_flag  = 1'b1;
                  if (sum8 != b4) begin
                    last_status_next = ST_CHECKSUM;
                  end else begin
                    last_status_next   = ST_OK;
                    last_humidity_next = {b0, b1};
                    last_temperature_next = b2[7] ? (16'd0 - {1'b0, mag}) : {1'b0, mag};
                  end
                end else begin
                  begin_pulse = 1'b1;
                  target      = PH_BIT_LOW;
                end
              end
            endcase
          end
        end
        default: ;  // idle: ignore the line
      endcase

      if (begin_pulse) begin
        // The edge sample is the first sample of the new pulse.
        if (timeout_of(target, cfg) == 8'd0) begin
          last_status_next = fail_of(target);
          phase_next       = PH_IDLE;
          done_flag        = 1'b1;
        end else begin
          pulse_ticks_next = 8'd1;
          phase_next       = target;
        end
      end
    end
  end

  always_comb begin
    res.drive_enable       = (phase_next == PH_START_LOW) || (phase_next == PH_START_HIGH);
    res.drive_value        = (phase_next == PH_START_HIGH);
    res.busy_res           = (phase_next != PH_IDLE);
    res.done_res           = done_flag;
    res.reused             = reused_flag;
    res.status             = last_status_next;
    res.humidity_tenths    = last_humidity_next;
    res.temperature_tenths = last_temperature_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      phase_ticks      <= '0;
      pulse_ticks      <= '0;
      low_pulse_length <= '0;
      bit_index        <= '0;
      frame_bits       <= '0;
      since_last_read  <= SINCE_MAX;
      last_status      <= ST_OK;
      last_humidity    <= '0;
      last_temperature <= '0;
    end else if (step) begin
      phase            <= phase_next;
      phase_ticks      <= phase_ticks_next;
      pulse_ticks      <= pulse_ticks_next;
      low_pulse_length <= low_pulse_length_next;
      bit_index        <= bit_index_next;
      frame_bits       <= frame_bits_next;
      since_last_read  <= since_last_read_next;
      last_status      <= last_status_next;
      last_humidity    <= last_humidity_next;
      last_temperature <= last_temperature_next;
    end
  end

  `SWR_ASSERT_PROP(a_done_returns_idle, step && res.done_res |=> phase == PH_IDLE, "done word left the sequence busy")
  `SWR_ASSERT_PROP(a_reused_keeps_state, step && res.reused |=> phase == PH_IDLE && $stable(since_last_read), "early answer disturbed the read state")
  `SWR_ASSERT_PROP(a_start_clears_interval, step && phase == PH_IDLE && phase_next == PH_START_LOW |=> since_last_read == 24'd0, "read started without clearing the interval count")
  `SWR_ASSERT_ALWAYS(a_bit_index_bound, bit_index <= 6'(FRAME_BITS), "bit index ran past the frame")

endmodule

// File: rtl/single_wire_sensor_frame_reader_top.sv
// Channel   Dir  Words                      Fields (low bit up)
// s_*       in   request or 1 us tick       tuser: action; tdata: line_level
// m_*       out  one status word per input  tdata: drive_enable .. temperature_tenths
// cfg_*     in   register write             cfg_index selects, cfg_data is the value
//
// Throughput: one word per clock while m_tready stays high; every input word yields one output word.
// Path: an accepted word passes through the input register, then the single-pass
// state update into the output register.
// Reset: synchronous rst clears the pipeline valids, the read state and loads the
// default timing registers; the interval count starts saturated.
// Stalls: a held output word back-pressures only when the input register is also full.
module single_wire_sensor_frame_reader_top (
  input  logic                             clk,
  input  logic                             rst,
  // input stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,   // [0] line_level, [7:1] zero
  input  logic                             s_tuser,   // [0] action
  // output stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [39:0]                      m_tdata,   // [0] drive_enable, [1] drive_value,
                                                      // [2] busy_res, [3] done_res,
                                                      // [4] reused, [6:5] status,
                                                      // [22:7] humidity_tenths,
                                                      // [38:23] temperature_tenths,
                                                      // [39] zero
  // configuration writes
  input  logic                             cfg_we,
  input  logic [swr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [swr_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import swr_pkg::*;

  cfg_t cfg;
  res_t res;
  res_t out_res;

  // Input register: holds one word until the state update can take it.
  logic in_valid;
  logic in_action;
  logic in_level;

  logic advance;  // output register free or draining this cycle
  logic step;     // apply the held word to the read state

  assign advance  = !m_tvalid || m_tready;
  assign step     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  // Capture payload on accept; no reset needed.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_action <= s_tuser;
      in_level  <= s_tdata[0];
    end
  end

  swr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  swr_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .action (in_action),
    .level  (in_level),
    .cfg    (cfg),
    .res    (res)
  );

  // Output register: advance whenever the downstream side has room.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= res;
    end
  end

  assign m_tdata = {1'b0,
                    out_res.temperature_tenths,
                    out_res.humidity_tenths,
                    out_res.status,
                    out_res.reused,
                    out_res.done_res,
                    out_res.busy_res,
                    out_res.drive_value,
                    out_res.drive_enable};

endmodule
